/* rtl/dcfc_pkg.sv */
// Shared types and constants for the distinct color Fenwick counter.
package dcfc_pkg;

  localparam int COUNT_W = 11;
  localparam int WALK_W  = COUNT_W + 1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [WALK_W-1:0]  walk_pos_t;

  localparam count_t SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_COLORIZE = 2'd0,
    OP_PREFIX   = 2'd1,
    OP_SUFFIX   = 2'd2,
    OP_NOP      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    WALK_REMOVE = 2'd0,
    WALK_ADD    = 2'd1,
    WALK_QUERY  = 2'd2
  } walk_sel_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_REMOVE,
    ST_ADD,
    ST_QUERY,
    ST_FINISH
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      clear_step;
    logic      capture;
    logic      walk_start;
    walk_sel_t walk_sel;
    logic      walk_run;
    logic      color_write;
    logic      result_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic    clear_done;
    logic    item_ok;
    logic    prev_valid;
    logic    walk_busy;
    opcode_t op;
  } dp_sts_t;

endpackage

/* rtl/dcfc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module dcfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dcfc_datapath.sv */
// Datapath: size register, item registers, tree walk unit, color table and result register.
module dcfc_datapath #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_COLORS    = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  dcfc_pkg::count_t  cfg_data,
  input  logic [1:0]        in_opcode,
  input  dcfc_pkg::count_t  in_position,
  input  dcfc_pkg::count_t  in_color,
  input  dcfc_pkg::dp_cmd_t cmd,
  output dcfc_pkg::dp_sts_t sts,
  output dcfc_pkg::count_t  out_count
);
  import dcfc_pkg::*;

  localparam int TREE_DEPTH = MAX_POSITIONS + 1;
  localparam int TA         = $clog2(TREE_DEPTH);
  localparam int CA         = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int CLR_DEPTH  = (TREE_DEPTH > MAX_COLORS) ? TREE_DEPTH : MAX_COLORS;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  count_t     size_r;
  opcode_t    op_r;
  count_t     pos_r;
  count_t     color_r;
  count_t     lim_r;
  count_t     lim_nxt;
  count_t     total_r;
  count_t     sum_r;
  count_t     out_count_r;
  walk_pos_t  walk_pos_r;
  walk_pos_t  walk_start_pos;
  walk_pos_t  walk_up;
  walk_pos_t  walk_down;
  walk_sel_t  sel_r;
  logic       pend_r;
  logic [TA-1:0]    pend_addr_r;
  logic [CLR_W-1:0] clr_cnt_r;
  logic       walk_active;
  count_t     query_pos;

  logic          tree_we;
  logic [TA-1:0] tree_waddr;
  count_t        tree_wdata;
  count_t        tree_rdata;
  logic          color_we;
  logic [CA-1:0] color_waddr;
  count_t        color_wdata;
  count_t        color_rdata;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_data;
    end
  end

  // Clamp the size into 1..MAX_POSITIONS
  always_comb begin
    if (size_r == '0) begin
      lim_nxt = COUNT_W'(1);
    end else if (32'(size_r) > 32'(MAX_POSITIONS)) begin
      lim_nxt = COUNT_W'(MAX_POSITIONS);
    end else begin
      lim_nxt = size_r;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode_t'(in_opcode);
      pos_r   <= in_position;
      color_r <= in_color;
      lim_r   <= lim_nxt;
    end
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  // Walk arithmetic: climb by the lowest set bit, descend by clearing it
  assign walk_up   = walk_pos_r + (walk_pos_r & (~walk_pos_r + WALK_W'(1)));
  assign walk_down = walk_pos_r & (walk_pos_r - WALK_W'(1));

  always_comb begin
    case (sel_r)
      WALK_QUERY: walk_active = (walk_pos_r != '0);
      default:    walk_active = (walk_pos_r != '0) && (walk_pos_r <= {1'b0, lim_r});
    endcase
  end

  // Query start: position, or the one before it for suffix, capped at the size
  always_comb begin
    if (op_r == OP_SUFFIX) begin
      query_pos = (pos_r == '0) ? '0 : pos_r - COUNT_W'(1);
    end else begin
      query_pos = pos_r;
    end
    if (query_pos > lim_r) begin
      query_pos = lim_r;
    end
  end

  always_comb begin
    case (cmd.walk_sel)
      WALK_REMOVE: walk_start_pos = {1'b0, color_rdata};
      WALK_ADD:    walk_start_pos = {1'b0, pos_r};
      WALK_QUERY:  walk_start_pos = {1'b0, query_pos};
      default:     walk_start_pos = '0;
    endcase
  end

  // Walk unit: issue one node read per cycle, write or sum it in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_pos_r <= '0;
      sel_r      <= WALK_ADD;
      pend_r     <= 1'b0;
    end else if (cmd.walk_start) begin
      walk_pos_r <= walk_start_pos;
      sel_r      <= cmd.walk_sel;
      pend_r     <= 1'b0;
    end else if (cmd.walk_run) begin
      pend_r <= walk_active;
      if (walk_active) begin
        walk_pos_r <= (sel_r == WALK_QUERY) ? walk_down : walk_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_run && walk_active) begin
      pend_addr_r <= TA'(walk_pos_r);
    end
  end

  // Prefix sum accumulator
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      sum_r <= '0;
    end else if (cmd.walk_run && pend_r && (sel_r == WALK_QUERY)) begin
      sum_r <= sum_r + tree_rdata;
    end
  end

  // Running total of marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.walk_start && (cmd.walk_sel == WALK_REMOVE)) begin
      total_r <= total_r - COUNT_W'(1);
    end else if (cmd.walk_start && (cmd.walk_sel == WALK_ADD)) begin
      total_r <= total_r + COUNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      case (op_r)
        OP_COLORIZE: out_count_r <= total_r;
        OP_PREFIX:   out_count_r <= sum_r;
        OP_SUFFIX:   out_count_r <= total_r - sum_r;
        default:     out_count_r <= '0;
      endcase
    end
  end

  assign out_count = out_count_r;

  // Tree memory ports
  assign tree_we    = cmd.clear_step || (pend_r && (sel_r != WALK_QUERY));
  assign tree_waddr = cmd.clear_step ? TA'(clr_cnt_r) : pend_addr_r;
  always_comb begin
    if (cmd.clear_step) begin
      tree_wdata = '0;
    end else if (sel_r == WALK_REMOVE) begin
      tree_wdata = tree_rdata - COUNT_W'(1);
    end else begin
      tree_wdata = tree_rdata + COUNT_W'(1);
    end
  end

  dcfc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TREE_DEPTH)
  ) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (TA'(walk_pos_r)),
    .rdata (tree_rdata)
  );

  // Color table ports: read at the incoming color, write the new position
  assign color_we    = cmd.clear_step || cmd.color_write;
  assign color_waddr = cmd.clear_step ? CA'(clr_cnt_r) : CA'(color_r - COUNT_W'(1));
  assign color_wdata = cmd.clear_step ? '0 : pos_r;

  dcfc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_COLORS)
  ) u_color_ram (
    .clk   (clk),
    .we    (color_we),
    .waddr (color_waddr),
    .wdata (color_wdata),
    .raddr (CA'(in_color - COUNT_W'(1))),
    .rdata (color_rdata)
  );

  // Status
  assign sts.clear_done = (clr_cnt_r == CLR_W'(CLR_DEPTH - 1));
  assign sts.item_ok    = (op_r == OP_COLORIZE) && (pos_r != '0) && (pos_r <= lim_r) &&
                          (color_r != '0) && (32'(color_r) <= 32'(MAX_COLORS));
  assign sts.prev_valid = (color_rdata != '0);
  assign sts.walk_busy  = walk_active || pend_r;
  assign sts.op         = op_r;

endmodule

/* rtl/dcfc_ctrl.sv */
// Controller: sequences clear, lookup, tree walks and result hand-off.
module dcfc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dcfc_pkg::dp_sts_t sts,
  output dcfc_pkg::dp_cmd_t cmd
);
  import dcfc_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        is_query;

  assign is_query = (sts.op == OP_PREFIX) || (sts.op == OP_SUFFIX);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (sts.item_ok) begin
          state_nxt = sts.prev_valid ? ST_REMOVE : ST_ADD;
        end else if (is_query) begin
          state_nxt = ST_QUERY;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_REMOVE: begin
        if (!sts.walk_busy) state_nxt = ST_ADD;
      end
      ST_ADD, ST_QUERY: begin
        if (!sts.walk_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.walk_sel = WALK_ADD;
    in_ready     = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOOKUP: begin
        if (sts.item_ok) begin
          cmd.color_write = 1'b1;
          cmd.walk_start  = 1'b1;
          cmd.walk_sel    = sts.prev_valid ? WALK_REMOVE : WALK_ADD;
        end else if (is_query) begin
          cmd.walk_start = 1'b1;
          cmd.walk_sel   = WALK_QUERY;
        end
      end
      ST_REMOVE: begin
        cmd.walk_run = 1'b1;
        if (!sts.walk_busy) begin
          cmd.walk_start = 1'b1;
          cmd.walk_sel   = WALK_ADD;
        end
      end
      ST_ADD, ST_QUERY: cmd.walk_run = 1'b1;
      ST_FINISH: cmd.result_load = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    if (cmd.result_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/distinct_color_fenwick_counter_core.sv */
// Top level of the distinct color Fenwick counter.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_size_in_use
//   in       in         in_valid / in_ready    in_opcode, in_position, in_color
//   out      out        out_valid / out_ready  out_count
//
// After reset the tree and color tables are swept to zero, one entry per cycle, over
// max(MAX_POSITIONS + 1, MAX_COLORS) entries (1025 by default); in_ready stays low meanwhile.
// From a transfer to the result: a lookup, then the tree walks, then a load; a walk
// visits at most 11 nodes at size 1024. Queries walk once, colorize twice when the
// color had an earlier mark; other items go from the lookup straight to the load.
// One item is in work at a time; a new item is taken while the last result waits on out_ready.
module distinct_color_fenwick_counter_core #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_COLORS    = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  dcfc_pkg::count_t cfg_size_in_use,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  dcfc_pkg::count_t in_position,
  input  dcfc_pkg::count_t in_color,
  output logic             out_valid,
  input  logic             out_ready,
  output dcfc_pkg::count_t out_count
);
  import dcfc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  dcfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcfc_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .MAX_COLORS    (MAX_COLORS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_size_in_use),
    .in_opcode   (in_opcode),
    .in_position (in_position),
    .in_color    (in_color),
    .cmd         (cmd),
    .sts         (sts),
    .out_count   (out_count)
  );

endmodule

/* rtl/dcfc_checker.sv */
// Port-level checks for the distinct color Fenwick counter, bound to the top level.
module dcfc_port_checks (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input dcfc_pkg::count_t out_count
);

  // Reset drops out_valid and starts the clear sweep
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or input ready active right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count))
    else $error("stalled result changed or dropped");

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // A new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

endmodule

bind distinct_color_fenwick_counter_core dcfc_port_checks u_dcfc_port_checks (.*);

/* verif/dcfc_checker.sv */
// Checker for the distinct color Fenwick counter: watches all channels, predicts and compares.
module dcfc_checker #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_COLORS    = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  dcfc_pkg::count_t cfg_size_in_use,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  dcfc_pkg::count_t in_position,
  input  dcfc_pkg::count_t in_color,
  input  logic             out_valid,
  input  logic             out_ready,
  input  dcfc_pkg::count_t out_count,
  output int               mismatch_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import dcfc_pkg::*;

  // Shadow copy of the block's stores
  count_t tree_cnt [1:MAX_POSITIONS];
  count_t color_last_pos [1:MAX_COLORS];
  count_t mark_total;
  count_t size_reg;

  // Expected counts, oldest first
  count_t expected_counts [$];

  function automatic int unsigned eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_POSITIONS) return MAX_POSITIONS;
    return 32'(size_reg);
  endfunction

  // Add delta along the update path, clipped at lim; the total always moves
  function automatic void walk_add(int unsigned pos, count_t delta, int unsigned lim);
    mark_total = mark_total + delta;
    while (pos != 0 && pos <= lim) begin
      tree_cnt[pos] = tree_cnt[pos] + delta;
      pos = pos + (pos & (~pos + 1));
    end
  endfunction

  function automatic count_t prefix_sum(int unsigned pos, int unsigned lim);
    count_t acc;
    acc = '0;
    if (pos > lim) pos = lim;
    while (pos != 0) begin
      acc = acc + tree_cnt[pos];
      pos = pos & (pos - 1);
    end
    return acc;
  endfunction

  // Apply one transfer to the shadow state and return the count it produces
  function automatic count_t predict_count(opcode_t op, count_t pos, count_t color);
    int unsigned lim;
    count_t prev;
    count_t result;
    lim = eff_size();
    result = '0;
    case (op)
      OP_COLORIZE: begin
        if (pos != 0 && pos <= lim && color != 0 && color <= MAX_COLORS) begin
          prev = color_last_pos[color];
          if (prev != 0) walk_add(32'(prev), '1, lim);
          color_last_pos[color] = pos;
          walk_add(32'(pos), count_t'(1), lim);
        end
        result = mark_total;
      end
      OP_PREFIX: result = prefix_sum(32'(pos), lim);
      OP_SUFFIX: result = mark_total -
                          ((pos == 0) ? count_t'(0) : prefix_sum(32'(pos) - 1, lim));
      default: result = '0;
    endcase
    return result;
  endfunction

  task automatic report_mismatch(input string what, input count_t exp_cnt, input count_t got);
    if (mismatch_count < 10)
      $display("[%0t] %s: expected count=%0d actual count=%0d", $realtime, what, exp_cnt, got);
    mismatch_count = mismatch_count + 1;
  endtask

  // Track transfers: results first, so an early result cannot hide behind a new item
  always @(posedge clk) begin : monitor
    count_t exp_cnt;
    if (!rst_n) begin
      for (int i = 1; i <= MAX_POSITIONS; i++) tree_cnt[i] = '0;
      for (int i = 1; i <= MAX_COLORS; i++) color_last_pos[i] = '0;
      mark_total = '0;
      size_reg = SIZE_RESET;
      expected_counts.delete();
      pending_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("result with nothing pending", 'x, out_count);
        end else begin
          exp_cnt = expected_counts.pop_front();
          if (out_count !== exp_cnt) report_mismatch("count mismatch", exp_cnt, out_count);
        end
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_size_in_use;
      if (in_valid && in_ready)
        expected_counts.push_back(predict_count(opcode_t'(in_opcode), in_position, in_color));
      pending_count <= expected_counts.size();
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the distinct color Fenwick counter: stimulus, idling and verdict.
module tb_top;
  import dcfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POSITIONS  = 1024;
  localparam int MAX_COLORS     = 1024;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 113;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  count_t     cfg_size_in_use = SIZE_RESET;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = OP_NOP;
  count_t     in_position = '0;
  count_t     in_color = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  count_t     out_count;
  int         mismatch_count;
  int         pending_count;

  // Idling controls and the current effective size
  logic        tx_no_gap = 1'b0;
  logic        rx_no_stall = 1'b0;
  int unsigned cur_eff = MAX_POSITIONS;
  int unsigned ready_wait = 0;
  int unsigned idle_cycles = 0;

  distinct_color_fenwick_counter_core #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .MAX_COLORS   (MAX_COLORS)
  ) uut (.*);

  dcfc_checker #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .MAX_COLORS   (MAX_COLORS)
  ) checker_i (.*);

  always #5 clk = ~clk;

  // Stall out_ready for a random number of cycles after each result transfer
  always @(posedge clk) begin : result_ready_ctl
    int unsigned nxt;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_wait <= 0;
    end else if (out_valid && out_ready) begin
      nxt = rx_no_stall ? 0 : $urandom_range(0, 11);
      ready_wait <= nxt;
      out_ready <= (nxt == 0);
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      out_ready <= (ready_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned eff_of(count_t v);
    if (v == 0) return 1;
    if (v > MAX_POSITIONS) return MAX_POSITIONS;
    return 32'(v);
  endfunction

  // Present one item after a random gap and hold it until the transfer
  task automatic send_item(input logic [1:0] op, input count_t pos, input count_t col);
    int unsigned gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_position <= pos;
    in_color <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain all pending results, then write the size register
  task automatic write_size(input count_t v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_size_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_eff = eff_of(v);
  endtask

  // Mostly legal operations with random content, plus raw noise
  function automatic void pick_random_item(input int unsigned eff, input int unsigned palette,
                                           output logic [1:0] op, output count_t pos,
                                           output count_t col);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    op = OP_NOP;
    pos = count_t'($urandom);
    col = count_t'($urandom);
    if (roll < 50) begin
      op = OP_COLORIZE;
      pos = count_t'($urandom_range(1, eff));
      col = count_t'($urandom_range(1, palette));
    end else if (roll < 70) begin
      op = OP_PREFIX;
      pos = count_t'($urandom_range(0, eff));
    end else if (roll < 90) begin
      op = OP_SUFFIX;
      pos = count_t'($urandom_range(0, eff));
    end else begin
      op = 2'($urandom_range(0, 3));
    end
  endfunction

  initial begin : stimulus
    count_t      phase_sizes [10];
    logic [1:0]  op;
    count_t      pos;
    count_t      col;
    int unsigned palette;

    // Hold reset, then release it once
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, moves, repeats and bad items at full size
    write_size(11'd1024);
    send_item(OP_COLORIZE, 11'd1, 11'd1);
    send_item(OP_COLORIZE, 11'd1024, 11'd1024);
    send_item(OP_COLORIZE, 11'd1024, 11'd1);
    send_item(OP_COLORIZE, 11'd1024, 11'd1);
    send_item(OP_COLORIZE, 11'd0, 11'd3);
    send_item(OP_COLORIZE, 11'd1025, 11'd3);
    send_item(OP_COLORIZE, 11'd2047, 11'd2047);
    send_item(OP_COLORIZE, 11'd5, 11'd0);
    send_item(OP_COLORIZE, 11'd5, 11'd1025);
    send_item(OP_PREFIX, 11'd0, 11'd0);
    send_item(OP_PREFIX, 11'd1024, 11'd0);
    send_item(OP_PREFIX, 11'd2047, 11'd2047);
    send_item(OP_SUFFIX, 11'd0, 11'd0);
    send_item(OP_SUFFIX, 11'd1, 11'd0);
    send_item(OP_SUFFIX, 11'd1024, 11'd0);
    send_item(OP_SUFFIX, 11'd2047, 11'd0);
    send_item(OP_NOP, 11'd2047, 11'd2047);

    // Shrink below recorded positions so the removal walk is clipped
    write_size(11'd3);
    send_item(OP_COLORIZE, 11'd2, 11'd1024);
    send_item(OP_PREFIX, 11'd3, 11'd0);
    send_item(OP_SUFFIX, 11'd1, 11'd0);
    send_item(OP_SUFFIX, 11'd0, 11'd0);

    // Size zero behaves as one
    write_size(11'd0);
    send_item(OP_COLORIZE, 11'd1, 11'd7);
    send_item(OP_PREFIX, 11'd2047, 11'd0);
    send_item(OP_SUFFIX, 11'd1, 11'd0);

    // Random phases over a spread of sizes, extremes included
    phase_sizes = '{11'd1024, 11'd1, 11'd2047, 11'd2, 11'd0, 11'd16, 11'd1000,
                    count_t'($urandom_range(1, 1024)), count_t'($urandom_range(3, 40)),
                    11'd1024};
    for (int ph = 0; ph < 10; ph++) begin
      write_size(phase_sizes[ph]);
      tx_no_gap = (ph % 3 == 1);
      rx_no_stall = (ph % 4 == 2);
      palette = (ph % 2 == 1) ? $urandom_range(1, 24) : MAX_COLORS;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_random_item(cur_eff, palette, op, pos, col);
        send_item(op, pos, col);
      end
    end

    // Drain, let the block settle, then judge
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
